### rtl/pva_pkg.sv
// pva_pkg: shared types, codes and sizes of the voice allocator
// no dependencies
`timescale 1ns / 1ps

package pva_pkg;

	localparam int NUM_VOICES = 16;
	localparam int AGE_BITS   = 16;

	localparam int IDX_W   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int CNT_W   = $clog2(NUM_VOICES + 1);
	localparam int PITCH_W = 16;
	localparam int FIN_W   = 4;
	localparam int VC_W    = 5;
	localparam int VOICE_W = 4;
	localparam int MASK_W  = 16;
	localparam int STAT_W  = 3;
	localparam int OP_W    = 2;

	// stream payload widths
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 24;

	// apb
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	typedef enum logic [OP_W-1:0] {
		OP_NOTE_ON  = 2'd0,
		OP_NOTE_OFF = 2'd1,
		OP_FINISHED = 2'd2,
		OP_UNUSED   = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_IGNORED  = 3'd0,
		STAT_FREE     = 3'd1,
		STAT_RETRIG   = 3'd2,
		STAT_STOLEN   = 3'd3,
		STAT_RELEASED = 3'd4,
		STAT_FIN_ACK  = 3'd5
	} stat_t;

	typedef enum logic [1:0] {
		REG_POLYPHONY = 2'd0,
		REG_RETRIGGER = 2'd1,
		REG_ONCE_MODE = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [PITCH_W-1:0]  pitch;
		logic [AGE_BITS-1:0] age;
	} voice_entry_t;

endpackage

### rtl/polyphonic_voice_allocator.sv
// polyphonic_voice_allocator: top level, voice table memory and scan sequencer
// depends on pva_pkg
`timescale 1ns / 1ps

// Voice allocator. Every note event is one beat on the s_ side and gives exactly one
// result beat on the m_ side. Pitch and age of each voice live in a one-port-write,
// registered-read table; the active bits sit in flops. A note-on or note-off walks the
// enabled voices one per cycle through that table: the reads, one read-latency stage,
// the close of the scan, for a note-on the final write of the chosen voice, then the
// result load; voice-finished, ignored and zero-voice note-on beats go straight to the
// result load. After the result load the block returns to idle and takes the next
// beat. The result sits in an output register, so a new beat is taken while the
// previous result still waits on m_tready. The user must write configuration through
// the APB port only while no beat is in flight; the block itself does not enforce it.
// Raising the polyphony register clears the active bits of the newly enabled voices in
// the same cycle. There is no clearing pass: voices whose pitch was never written
// compare as pitch zero, as after reset.
module polyphonic_voice_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	// input stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [pva_pkg::S_DATA_W-1:0] s_tdata,  // [15:0] pitch, [19:16] finished_voice
	input  logic [pva_pkg::OP_W-1:0]    s_tuser,   // [1:0] operation
	// result stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [pva_pkg::M_DATA_W-1:0] m_tdata,  // [3:0] voice, [19:4] release_mask,
	                                               // [20] immediate_stop
	output logic [pva_pkg::STAT_W-1:0]  m_tuser,   // [2:0] status
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pva_pkg::ADDR_W-1:0]  paddr,
	input  logic [pva_pkg::DATA_W-1:0]  pwdata,
	output logic [pva_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import pva_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINAL,
		ST_DONE
	} state_t;

	state_t state_q;

	// configuration registers
	logic [VC_W-1:0] polyphony_q;
	logic            retrig_q;
	logic            once_q;

	// per-voice flags
	logic [NUM_VOICES-1:0] active_q;
	logic [NUM_VOICES-1:0] written_q;   // pitch entry ever written

	// latched beat
	op_t                op_q;
	logic [PITCH_W-1:0] pitch_q;
	logic [FIN_W-1:0]   fin_q;

	// scan pipeline
	logic [CNT_W-1:0] rd_idx_q;
	logic             valid_s1;
	logic [IDX_W-1:0] idx_s1;

	// scan results
	logic             match_hit_q, free_hit_q;
	logic [IDX_W-1:0] match_q, free_q, oldest_q;
	logic [AGE_BITS-1:0] oldest_age_q;
	logic [NUM_VOICES-1:0] mask_q;

	// result being built and output register
	stat_t            res_stat_q;
	logic [IDX_W-1:0] res_voice_q;
	logic             res_imm_q;
	logic             out_valid_q;
	stat_t            out_stat_q;
	logic [VOICE_W-1:0] out_voice_q;
	logic [MASK_W-1:0]  out_mask_q;
	logic             out_imm_q;

	// voice table
	voice_entry_t vmem [NUM_VOICES];
	voice_entry_t rdata_q;
	logic         mem_we;
	logic [IDX_W-1:0] mem_waddr;
	voice_entry_t mem_wdata;
	logic [IDX_W-1:0] mem_raddr;

	// input fields
	logic [PITCH_W-1:0] in_pitch;
	logic [FIN_W-1:0]   in_fin;
	op_t                in_op;
	assign in_pitch = s_tdata[15:0];
	assign in_fin   = s_tdata[19:16];
	assign in_op    = op_t'(s_tuser);

	// effective voice count
	logic [CNT_W-1:0] n_eff;
	assign n_eff = (int'(polyphony_q) < NUM_VOICES) ? CNT_W'(polyphony_q)
	                                                : CNT_W'(NUM_VOICES);

	logic s_fire, cfg_wr, issue, scan_end;
	assign s_tready = (state_q == ST_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign issue    = (state_q == ST_SCAN) && (rd_idx_q < n_eff);
	assign scan_end = (state_q == ST_SCAN) && !issue && !valid_s1;

	// stage 1: entry read back, never-written pitch reads as zero
	logic [PITCH_W-1:0]  pitch_eff;
	logic [AGE_BITS-1:0] age_new;
	logic                act_s1, pitch_eq;
	assign pitch_eff = written_q[idx_s1] ? rdata_q.pitch : '0;
	assign act_s1    = active_q[idx_s1];
	assign age_new   = (rdata_q.age == {AGE_BITS{1'b1}}) ? rdata_q.age
	                                                     : rdata_q.age + 1'b1;
	assign pitch_eq  = (pitch_eff == pitch_q);

	// finished index, widened or narrowed to the voice index
	logic [IDX_W+FIN_W-1:0] fin_ext;
	logic [IDX_W-1:0]       fin_idx;
	assign fin_ext = {{IDX_W{1'b0}}, fin_q};
	assign fin_idx = fin_ext[IDX_W-1:0];

	// choice at end of note-on scan
	logic [IDX_W-1:0] chosen;
	stat_t            chosen_stat;
	always_comb begin
		if (match_hit_q) begin
			chosen      = match_q;
			chosen_stat = STAT_RETRIG;
		end else if (free_hit_q) begin
			chosen      = free_q;
			chosen_stat = STAT_FREE;
		end else begin
			chosen      = oldest_q;
			chosen_stat = STAT_STOLEN;
		end
	end

	// table write port: aged entries during scan, then the chosen voice
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = '{pitch: rdata_q.pitch, age: age_new};
		if (state_q == ST_SCAN && valid_s1 && op_q == OP_NOTE_ON && act_s1) begin
			mem_we = 1'b1;
		end else if (state_q == ST_FINAL) begin
			mem_we    = 1'b1;
			mem_waddr = chosen;
			mem_wdata = '{pitch: pitch_q, age: '0};
		end
	end
	assign mem_raddr = rd_idx_q[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			vmem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= vmem[mem_raddr];
	end

	// raising the voice count clears the newly enabled voices
	logic [CNT_W-1:0] n_new;
	logic [NUM_VOICES-1:0] clr_mask;
	always_comb begin
		n_new = (int'(pwdata[VC_W-1:0]) < NUM_VOICES) ? CNT_W'(pwdata[VC_W-1:0])
		                                             : CNT_W'(NUM_VOICES);
		for (int i = 0; i < NUM_VOICES; i++) begin
			clr_mask[i] = (i >= int'(n_eff)) && (i < int'(n_new));
		end
	end

	// result widening or truncation to the port widths
	logic [IDX_W+VOICE_W-1:0]     voice_ext;
	logic [NUM_VOICES+MASK_W-1:0] mask_ext;
	assign voice_ext = {{VOICE_W{1'b0}}, res_voice_q};
	assign mask_ext  = {{MASK_W{1'b0}}, mask_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			polyphony_q   <= VC_W'(8);
			retrig_q      <= 1'b0;
			once_q        <= 1'b0;
			active_q      <= '0;
			written_q     <= '0;
			op_q          <= OP_NOTE_ON;
			pitch_q       <= '0;
			fin_q         <= '0;
			rd_idx_q      <= '0;
			valid_s1      <= 1'b0;
			idx_s1        <= '0;
			match_hit_q   <= 1'b0;
			free_hit_q    <= 1'b0;
			match_q       <= '0;
			free_q        <= '0;
			oldest_q      <= '0;
			oldest_age_q  <= '0;
			mask_q        <= '0;
			res_stat_q    <= STAT_IGNORED;
			res_voice_q   <= '0;
			res_imm_q     <= 1'b0;
			out_valid_q   <= 1'b0;
			out_stat_q    <= STAT_IGNORED;
			out_voice_q   <= '0;
			out_mask_q    <= '0;
			out_imm_q     <= 1'b0;
		end else begin
			// the done state reloads the output register itself
			if (out_valid_q && m_tready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end

			// configuration; the user writes it only while idle, the block does not enforce it
			if (cfg_wr) begin
				case (paddr[3:2])
					REG_POLYPHONY: begin
						polyphony_q <= pwdata[VC_W-1:0];
						active_q    <= active_q & ~clr_mask;
					end
					REG_RETRIGGER: retrig_q <= pwdata[0];
					REG_ONCE_MODE: once_q   <= pwdata[0];
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						op_q        <= in_op;
						pitch_q     <= in_pitch;
						fin_q       <= in_fin;
						rd_idx_q    <= '0;
						valid_s1    <= 1'b0;
						match_hit_q <= 1'b0;
						free_hit_q  <= 1'b0;
						oldest_q    <= '0;
						oldest_age_q <= '0;
						mask_q      <= '0;
						// only an in-range finish is acknowledged
						res_stat_q  <= (in_op == OP_FINISHED && int'(in_fin) < NUM_VOICES)
						               ? STAT_FIN_ACK : STAT_IGNORED;
						res_voice_q <= '0;
						res_imm_q   <= 1'b0;
						case (in_op)
							OP_NOTE_ON: begin
								state_q <= (n_eff != '0) ? ST_SCAN : ST_DONE;
							end
							OP_NOTE_OFF: begin
								state_q <= ST_SCAN;
							end
							OP_FINISHED: begin
								state_q <= ST_DONE;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_SCAN: begin
					valid_s1 <= issue;
					idx_s1   <= rd_idx_q[IDX_W-1:0];
					if (issue) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (valid_s1) begin
						if (op_q == OP_NOTE_ON) begin
							if (retrig_q && pitch_eq) begin
								match_hit_q <= 1'b1;
								match_q     <= idx_s1;
							end
							if (act_s1) begin
								// first active age seeds the running maximum
								if (idx_s1 == '0 || age_new > oldest_age_q) begin
									oldest_q     <= idx_s1;
									oldest_age_q <= age_new;
								end
							end else if (!free_hit_q) begin
								free_hit_q <= 1'b1;
								free_q     <= idx_s1;
							end
						end else begin
							mask_q[idx_s1] <= act_s1 && pitch_eq;
						end
					end
					if (scan_end) begin
						if (op_q == OP_NOTE_ON) begin
							state_q <= ST_FINAL;
						end else begin
							res_stat_q <= STAT_RELEASED;
							res_imm_q  <= once_q;
							state_q    <= ST_DONE;
						end
					end
				end
				ST_FINAL: begin
					active_q[chosen]  <= 1'b1;
					written_q[chosen] <= 1'b1;
					res_stat_q        <= chosen_stat;
					res_voice_q       <= chosen;
					state_q           <= ST_DONE;
				end
				ST_DONE: begin
					if (op_q == OP_FINISHED && res_stat_q == STAT_FIN_ACK) begin
						active_q[fin_idx] <= 1'b0;
					end
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_stat_q  <= res_stat_q;
						out_voice_q <= voice_ext[VOICE_W-1:0];
						out_mask_q  <= mask_ext[MASK_W-1:0];
						out_imm_q   <= res_imm_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// finished clear repeats every cycle the done state waits for the output,
	// which leaves the same bit cleared

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_stat_q;
	assign m_tdata  = {3'b000, out_imm_q, out_mask_q, out_voice_q};

	always_comb begin
		case (paddr[3:2])
			REG_POLYPHONY: prdata = {{(DATA_W-VC_W){1'b0}}, polyphony_q};
			REG_RETRIGGER: prdata = {{(DATA_W-1){1'b0}}, retrig_q};
			REG_ONCE_MODE: prdata = {{(DATA_W-1){1'b0}}, once_q};
			default:       prdata = '0;
		endcase
	end

	// no scan beat left in flight once a new beat can be taken
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !valid_s1)
		else $error("scan stage still valid while idle");

	// aging write never lands on the entry being read in the same cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && issue) |-> (mem_waddr != mem_raddr))
		else $error("table read and write hit the same voice");

	// the chosen voice is active right after the final write
	a_chosen_active: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINAL) |=> active_q[$past(chosen)])
		else $error("chosen voice not activated");

	// the final step always leads to the done state with an allocation status
	a_final_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINAL) |=> (state_q == ST_DONE)
			&& (res_stat_q == STAT_FREE || res_stat_q == STAT_RETRIG
			|| res_stat_q == STAT_STOLEN))
		else $error("note-on did not produce an allocation status");

endmodule

### verif/polyphonic_voice_allocator_test.sv
// polyphonic_voice_allocator_test: self-checking bench for the voice allocator
// holds a cycle-free predictor of the voice table, a stream driver and a result monitor
// depends on pva_pkg and rtl/polyphonic_voice_allocator.sv
`timescale 1ns / 1ps

module polyphonic_voice_allocator_test;
	import pva_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYCLES = 12;
	localparam int SETTLE = 24;          // idle margin that covers the longest scan, over all 16 voices
	localparam int HOLD_AT_RESULT = 300; // result count that starts the long back-pressure
	localparam int HOLD_CYCLES = 300;
	localparam int TIMEOUT_NS = 2_000_000;
	localparam int MAX_REPORTS = 10;

	// one note event as it travels on the input stream
	typedef struct {
		op_t              op;
		logic [15:0]      pitch;
		logic [FIN_W-1:0] fin;
	} note_event_t;

	// one allocation result as it travels on the result stream
	typedef struct {
		stat_t              status;
		logic [VOICE_W-1:0] voice;
		logic [MASK_W-1:0]  mask;
		logic               imm;
	} voice_result_t;

	// one random phase: register setting and how many beats to send under it
	typedef struct {
		int voices;
		bit retrig;
		bit once;
		int beats;
		bit steady;
	} phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;   // [15:0] pitch, [19:16] finished_voice
	logic [OP_W-1:0]     s_tuser = '0;   // [1:0] operation
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;        // [3:0] voice, [19:4] release_mask, [20] immediate_stop
	logic [STAT_W-1:0]   m_tuser;        // [2:0] status

	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	polyphonic_voice_allocator dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// predictor copy of the voice table and the registers
	logic              ch_active [NUM_VOICES];
	logic [15:0]       ch_pitch  [NUM_VOICES];
	logic [AGE_BITS-1:0] ch_age  [NUM_VOICES];
	logic [VC_W-1:0]   cfg_voices = 5'd8;
	logic              cfg_retrig = 1'b0;
	logic              cfg_once = 1'b0;

	note_event_t   pending_events[$];   // beats not yet offered
	voice_result_t awaited_results[$];  // predicted results, oldest first
	note_event_t   on_bus;              // beat currently offered on s_

	bit no_gaps = 1'b0;   // both sides run flat out while set
	int beats_sent = 0;
	int results_seen = 0;
	int mismatches = 0;
	int settings_used = 1;
	int stat_hits [8];

	// pitches that recur often so that retrigger and release masks get hits
	logic [15:0] hot_pitch [6] = '{16'h0000, 16'h0100, 16'hFF00, 16'h8000, 16'h7FFF, 16'h3C55};

	phase_t plan [9] = '{
		'{16, 1'b1, 1'b0, 120, 1'b0},
		'{ 4, 1'b0, 1'b1, 100, 1'b0},
		'{31, 1'b1, 1'b1, 100, 1'b1},   // above the voice count: scans all 16
		'{ 1, 1'b0, 1'b0,  60, 1'b0},
		'{ 0, 1'b1, 1'b1,  20, 1'b0},   // no voices: every note-on is ignored
		'{16, 1'b0, 1'b1, 120, 1'b0},
		'{12, 1'b1, 1'b0, 100, 1'b0},
		'{20, 1'b0, 1'b0, 100, 1'b0},
		'{ 7, 1'b1, 1'b1,  80, 1'b0}
	};

	initial begin
		for (int i = 0; i < NUM_VOICES; i++) begin
			ch_active[i] = 1'b0;
			ch_pitch[i] = '0;
			ch_age[i] = '0;
		end
		for (int i = 0; i < 8; i++)
			stat_hits[i] = 0;
	end

	function automatic int live_voices();
		return (cfg_voices < NUM_VOICES) ? int'(cfg_voices) : NUM_VOICES;
	endfunction

	// works out the result of one note event and advances the predicted voice table
	function automatic voice_result_t allocate(note_event_t ev);
		voice_result_t r;
		int n;
		int match;
		int free_v;
		int oldest;
		int chosen;
		n = live_voices();
		r.status = STAT_IGNORED;
		r.voice = '0;
		r.mask = '0;
		r.imm = 1'b0;
		case (ev.op)
			OP_NOTE_ON: begin
				if (n > 0) begin
					match = -1;
					free_v = -1;
					oldest = 0;
					// one pass: age the active voices, track last match, first free, oldest
					for (int i = 0; i < n; i++) begin
						if (cfg_retrig && ch_pitch[i] == ev.pitch)
							match = i;
						if (ch_active[i]) begin
							if (ch_age[i] != '1)
								ch_age[i] = ch_age[i] + 1'b1;
							if (ch_age[i] > ch_age[oldest])
								oldest = i;
						end else if (free_v < 0 && match < 0) begin
							free_v = i;
						end
					end
					if (match >= 0) begin
						chosen = match;
						r.status = STAT_RETRIG;
					end else if (free_v >= 0) begin
						chosen = free_v;
						r.status = STAT_FREE;
					end else begin
						chosen = oldest;
						r.status = STAT_STOLEN;
					end
					ch_active[chosen] = 1'b1;
					ch_pitch[chosen] = ev.pitch;
					ch_age[chosen] = '0;
					r.voice = chosen[VOICE_W-1:0];
				end
			end
			OP_NOTE_OFF: begin
				// state untouched; voices stay active until their finish beat
				for (int i = 0; i < n; i++)
					if (ch_active[i] && ch_pitch[i] == ev.pitch)
						r.mask[i] = 1'b1;
				r.status = STAT_RELEASED;
				r.imm = cfg_once;
			end
			OP_FINISHED: begin
				// any index in the table, even above the live count
				if (int'(ev.fin) < NUM_VOICES) begin
					ch_active[ev.fin] = 1'b0;
					r.status = STAT_FIN_ACK;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic note_event_t make_note(op_t op, logic [15:0] pitch, logic [FIN_W-1:0] fin);
		note_event_t ev;
		ev.op = op;
		ev.pitch = pitch;
		ev.fin = fin;
		return ev;
	endfunction

	// mostly note-ons against a small pitch pool, with releases, finishes and some junk
	function automatic note_event_t random_note();
		note_event_t ev;
		int pick;
		pick = $urandom_range(99);
		if (pick < 50)
			ev.op = OP_NOTE_ON;
		else if (pick < 75)
			ev.op = OP_NOTE_OFF;
		else if (pick < 95)
			ev.op = OP_FINISHED;
		else
			ev.op = OP_UNUSED;
		if ($urandom_range(99) < 70)
			ev.pitch = hot_pitch[$urandom_range(5)];
		else
			ev.pitch = 16'($urandom);
		ev.fin = FIN_W'($urandom);
		return ev;
	endfunction

	// register write: setup beat, access beat, then the model follows the write edge
	task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
		int old_n;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_POLYPHONY: begin
				// raising the count frees the newly enabled voices
				old_n = live_voices();
				cfg_voices = value[VC_W-1:0];
				for (int i = old_n; i < live_voices(); i++)
					ch_active[i] = 1'b0;
			end
			REG_RETRIGGER: cfg_retrig = value[0];
			REG_ONCE_MODE: cfg_once = value[0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic write_setting(int voices, bit retrig, bit once);
		write_reg(REG_POLYPHONY, DATA_W'(voices));
		write_reg(REG_RETRIGGER, DATA_W'(retrig));
		write_reg(REG_ONCE_MODE, DATA_W'(once));
		settings_used++;
	endtask

	// block is idle once every queued beat went out and every result came back
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_events.size() != 0 || s_tvalid || awaited_results.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic queue_note(op_t op, logic [15:0] pitch, logic [FIN_W-1:0] fin);
		pending_events.push_back(make_note(op, pitch, fin));
	endtask

	// driver: offers queued beats, idling at random unless no_gaps is set;
	// every accepted beat goes through the predictor at its accept edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				awaited_results.push_back(allocate(on_bus));
				beats_sent <= beats_sent + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_events.size() != 0 && (no_gaps || $urandom_range(99) >= 21)) begin
					on_bus = pending_events.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {4'b0000, on_bus.fin, on_bus.pitch};
					s_tuser <= on_bus.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver ready: random stalls, plus one long hold-off counted here
	// that lets the output register fill and the input side back up
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && results_seen == HOLD_AT_RESULT) begin
			m_tready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			m_tready <= no_gaps || ($urandom_range(99) >= 21);
		end
	end

	// monitor: each result beat against the oldest prediction, field by field
	always @(posedge clk) begin
		voice_result_t want;
		voice_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen <= results_seen + 1;
			got.status = stat_t'(m_tuser);
			got.voice = m_tdata[3:0];
			got.mask = m_tdata[19:4];
			got.imm = m_tdata[20];
			stat_hits[m_tuser] = stat_hits[m_tuser] + 1;
			if (awaited_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result beat with nothing awaited: status %0d voice %0d",
						$time, m_tuser, got.voice);
			end else begin
				want = awaited_results.pop_front();
				if (got.status !== want.status || got.voice !== want.voice ||
						got.mask !== want.mask || got.imm !== want.imm) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: beat %0d expected status %0d voice %0d mask %h stop %b,",
							$time, results_seen, want.status, want.voice, want.mask, want.imm,
							" got status %0d voice %0d mask %h stop %b",
							got.status, got.voice, got.mask, got.imm);
				end
			end
		end
	end

	// stimulus and phase control
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset setting: 8 voices, no retrigger, release mode
		queue_note(OP_NOTE_OFF, 16'h0000, 4'd0);   // nothing active: empty mask
		queue_note(OP_NOTE_ON, 16'h8000, 4'd0);
		queue_note(OP_NOTE_ON, 16'h7FFF, 4'd15);
		queue_note(OP_NOTE_ON, 16'hFFFF, 4'd0);
		queue_note(OP_NOTE_ON, 16'h0000, 4'd0);
		queue_note(OP_NOTE_ON, 16'h0100, 4'd0);
		queue_note(OP_NOTE_ON, 16'h0100, 4'd0);   // same pitch without retrigger: new voice
		queue_note(OP_NOTE_ON, 16'h1234, 4'd0);
		queue_note(OP_NOTE_ON, 16'h5555, 4'd0);
		queue_note(OP_NOTE_ON, 16'hAAAA, 4'd0);   // table full: steal oldest
		queue_note(OP_NOTE_OFF, 16'h0100, 4'd0);  // two voices in the mask
		queue_note(OP_FINISHED, 16'h0000, 4'd3);
		queue_note(OP_FINISHED, 16'hFFFF, 4'd15); // above the live count, still cleared
		queue_note(OP_UNUSED, 16'hFFFF, 4'd15);
		queue_note(OP_NOTE_ON, 16'h0000, 4'd0);   // reuses the finished voice
		wait_idle();

		write_setting(8, 1'b1, 1'b1);
		queue_note(OP_NOTE_ON, 16'h0100, 4'd0);   // retrigger picks the last match
		queue_note(OP_NOTE_OFF, 16'h7FFF, 4'd0);  // immediate stop flag set
		wait_idle();
		write_reg(REG_POLYPHONY, DATA_W'(0));
		queue_note(OP_NOTE_ON, 16'h1234, 4'd0);   // no voices: ignored
		queue_note(OP_NOTE_OFF, 16'h1234, 4'd0);
		wait_idle();
		write_reg(REG_POLYPHONY, DATA_W'(16));    // raise to full table
		queue_note(OP_NOTE_ON, 16'h0000, 4'd0);   // matches an inactive voice holding zero
		queue_note(OP_FINISHED, 16'h0000, 4'd0);
		queue_note(OP_NOTE_ON, 16'h00FF, 4'd0);
		wait_idle();

		// random phases across register settings
		foreach (plan[p]) begin
			write_setting(plan[p].voices, plan[p].retrig, plan[p].once);
			no_gaps = plan[p].steady;
			repeat (plan[p].beats) pending_events.push_back(random_note());
			wait_idle();
			no_gaps = 1'b0;
		end

		repeat (2 * SETTLE) @(posedge clk);
		$display("checked %0d result beats over %0d register settings, %0d beats left over",
			results_seen, settings_used, awaited_results.size());
		$display("free %0d, retrigger %0d, steal %0d, release %0d, finish %0d, ignored %0d",
			stat_hits[STAT_FREE], stat_hits[STAT_RETRIG], stat_hits[STAT_STOLEN],
			stat_hits[STAT_RELEASED], stat_hits[STAT_FIN_ACK], stat_hits[STAT_IGNORED]);
		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAIL");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("timeout with %0d results awaited", awaited_results.size());
		$display("FAIL");
		$finish;
	end

endmodule
